/* rtl/bcc_pkg.sv */
// Shared definitions for the button click classifier: item layouts,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned TICK_W   = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 152;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_WINDOW = 1'd1;

    localparam logic [CFG_W-1:0] SHORT_LIMIT_RST  = 16'd400;
    localparam logic [CFG_W-1:0] MULTI_WINDOW_RST = 16'd300;

    // Packed structs list the highest bits first, so the first field is last.
    typedef struct packed {
        logic [5:0]         pad;
        logic [COUNT_W-1:0] press_target;
        logic               query_enable;
        logic [TICK_W-1:0]  now_tick;
        logic               pressed_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         pad;
        logic [TICK_W-1:0]  last_release_time;
        logic [TICK_W-1:0]  last_press_time;
        logic [COUNT_W-1:0] release_tally;
        logic [COUNT_W-1:0] consecutive_count;
        logic [TICK_W-1:0]  gap_ticks;
        logic [TICK_W-1:0]  hold_ticks;
        logic               multi_press_hit;
        logic               long_click;
        logic               short_click;
        logic               new_release;
        logic               new_press;
        logic               is_pressed;
    } t_out_item;

endpackage

/* rtl/button_click_classifier.sv */
// An accepted item waits in the input register; its result is then registered in the
// result register, which drives the output. Throughput: one item per cycle while the
// receiver takes results; the input register and the result register form a two-stage
// flow-controlled pipeline, and the classifier state updates in one pass. Reset
// (i_rst_n low, synchronous) empties both stages, clears all tracking state and loads
// the limit registers with 400 and 300 ticks. No clearing pass is needed.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module button_click_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]     i_cfg_data,
    // Input items. tdata from bit 0: pressed_level, now_tick, query_enable,
    // press_target, zero padding.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bcc_pkg::IN_W-1:0]      i_s_tdata,
    // Result items. tdata from bit 0: is_pressed, new_press, new_release,
    // short_click, long_click, multi_press_hit, hold_ticks, gap_ticks,
    // consecutive_count, release_tally, last_press_time, last_release_time,
    // zero padding.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bcc_pkg::OUT_W-1:0]     o_m_tdata
);
    import bcc_pkg::*;

    // Configuration registers. Writes are always taken.
    logic [CFG_W-1:0] r_short_limit;
    logic [CFG_W-1:0] r_multi_window;

    // Pipeline control and payload.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      advance;

    // Classifier state.
    logic               r_primed;
    logic               r_held_level;
    logic [TICK_W-1:0]  r_press_stamp;
    logic [TICK_W-1:0]  r_release_stamp;
    logic [TICK_W-1:0]  r_hold_length;
    logic [TICK_W-1:0]  r_gap_length;
    logic [COUNT_W-1:0] r_burst_count;
    logic [COUNT_W-1:0] r_release_counter;

    logic               n_held_level;
    logic [TICK_W-1:0]  n_press_stamp;
    logic [TICK_W-1:0]  n_release_stamp;
    logic [TICK_W-1:0]  n_hold_length;
    logic [TICK_W-1:0]  n_gap_length;
    logic [COUNT_W-1:0] n_burst_count;
    logic [COUNT_W-1:0] n_release_counter;
    logic               rise;
    logic               fall;
    logic               hit;

    assign o_cfg_ready = 1'b1;

    // The stored item moves on when the result register is empty or being drained.
    // Because of that, a new item is taken while a finished result waits if the input register is empty.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit  <= SHORT_LIMIT_RST;
            r_multi_window <= MULTI_WINDOW_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHORT_LIMIT:  r_short_limit  <= i_cfg_data;
                REG_MULTI_WINDOW: r_multi_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= t_in_item'(i_s_tdata);
        end
    end

    // One-pass update of the classifier for the item in the input register.
    // The first item after reset only samples the level: a button held at
    // start-up leaves the release counter at zero, so its release is not counted.
    always_comb begin
        n_held_level      = r_held_level;
        n_press_stamp     = r_press_stamp;
        n_release_stamp   = r_release_stamp;
        n_hold_length     = r_hold_length;
        n_gap_length      = r_gap_length;
        n_burst_count     = r_burst_count;
        n_release_counter = r_release_counter;
        rise              = 1'b0;
        fall              = 1'b0;
        hit               = 1'b0;

        if (!r_primed) begin
            n_held_level      = r_in.pressed_level;
            n_release_counter = r_in.pressed_level ? '0 : COUNT_W'(1);
        end else begin
            if (r_in.pressed_level != r_held_level) begin
                n_held_level = r_in.pressed_level;
                if (r_in.pressed_level) begin
                    n_press_stamp = r_in.now_tick;
                    rise          = 1'b1;
                end else begin
                    if (r_release_counter != '0) begin
                        n_release_stamp = r_in.now_tick;
                        fall            = 1'b1;
                    end
                    n_release_counter = r_release_counter + COUNT_W'(1);
                end
            end
            // Durations only move forward; a time earlier than the stamp keeps
            // the old length.
            if (n_held_level) begin
                if (r_in.now_tick >= n_press_stamp) begin
                    n_hold_length = r_in.now_tick - n_press_stamp;
                end
            end else if (r_in.now_tick >= n_release_stamp) begin
                n_gap_length = r_in.now_tick - n_release_stamp;
                if (n_gap_length > TICK_W'(r_multi_window)) begin
                    n_burst_count = '0;
                end
            end
            if (fall) begin
                n_burst_count = n_burst_count + COUNT_W'(1);
            end
            // The query sees the count after this item's own release.
            if (r_in.query_enable && (n_burst_count >= r_in.press_target)) begin
                n_burst_count = '0;
                hit           = 1'b1;
            end
        end

        n_out                   = '0;
        n_out.is_pressed        = n_held_level;
        n_out.new_press         = rise;
        n_out.new_release       = fall;
        n_out.short_click       = fall && (n_hold_length <= TICK_W'(r_short_limit));
        n_out.long_click        = fall && (n_hold_length > TICK_W'(r_short_limit));
        n_out.multi_press_hit   = hit;
        n_out.hold_ticks        = n_hold_length;
        n_out.gap_ticks         = n_gap_length;
        n_out.consecutive_count = n_burst_count;
        n_out.release_tally     = n_release_counter;
        n_out.last_press_time   = n_press_stamp;
        n_out.last_release_time = n_release_stamp;
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed          <= 1'b0;
            r_held_level      <= 1'b0;
            r_press_stamp     <= '0;
            r_release_stamp   <= '0;
            r_hold_length     <= '0;
            r_gap_length      <= '0;
            r_burst_count     <= '0;
            r_release_counter <= '0;
        end else if (advance) begin
            r_primed          <= 1'b1;
            r_held_level      <= n_held_level;
            r_press_stamp     <= n_press_stamp;
            r_release_stamp   <= n_release_stamp;
            r_hold_length     <= n_hold_length;
            r_gap_length      <= n_gap_length;
            r_burst_count     <= n_burst_count;
            r_release_counter <= n_release_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // A counted release is classed as exactly one kind of click.
    a_click_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.short_click || r_out.long_click) == r_out.new_release)
                        && !(r_out.short_click && r_out.long_click))
        else $error("click class does not match release");

    // A hit always leaves the consecutive count cleared.
    a_hit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.multi_press_hit) |-> (r_out.consecutive_count == '0))
        else $error("multi-press hit left count set");

    // Edges agree with the reported level.
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.new_press || r_out.is_pressed)
                        && (!r_out.new_release || !r_out.is_pressed))
        else $error("edge flag disagrees with level");

    // A new result only appears after an item sat in the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_in_valid))
        else $error("result appeared without an item");
`endif

endmodule

/* tb/button_click_classifier_tb.sv */
// Self-checking testbench for button_click_classifier: random and directed button
// samples, an in-bench click classifier that predicts every result, and random stalls.
// Depends on bcc_pkg and the button_click_classifier RTL.
`timescale 1ns / 1ps

module button_click_classifier_tb;

    import bcc_pkg::*;

    // Depth of the block's pipeline from sample to result; the drain waits past it.
    localparam int unsigned RESULT_LATENCY = 2;

    // Clock period is 8 ns: 4 ns high, 4 ns low.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SHORT_LIMIT;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;

    button_click_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Chance, in percent, that the sender holds back an item or the receiver stalls
    // in a given cycle. Changed between phases.
    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 57;

    // Mirror of the classifier state and of its two limit registers.
    logic        m_primed       = 1'b0;
    logic        m_level        = 1'b0;
    logic [31:0] m_press_at     = '0;
    logic [31:0] m_release_at   = '0;
    logic [31:0] m_hold         = '0;
    logic [31:0] m_gap          = '0;
    logic [7:0]  m_burst        = '0;
    logic [7:0]  m_releases     = '0;
    logic [15:0] m_short_limit  = SHORT_LIMIT_RST;
    logic [15:0] m_window       = MULTI_WINDOW_RST;

    // Predicted results, oldest first, and the bookkeeping of the run.
    t_out_item   expected_clicks[$];
    int unsigned mismatches     = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned short_seen     = 0;
    int unsigned long_seen      = 0;
    int unsigned hits_seen      = 0;

    // Running time and button level used to build well-formed click sequences.
    logic [31:0] stim_time      = '0;
    logic        stim_level     = 1'b0;

    // Hard limit on the run.
    initial begin
        #1_000_000;
        $display("Timeout: results still outstanding: %0d", expected_clicks.size());
        $display("** button_click_classifier: FAILED **");
        $finish;
    end

    // Applies one sample to the mirrored state and returns the result the block must give.
    // Everything happens in the order the block does it: edge detection, duration update
    // (which may clear the burst after a quiet window), burst increment, then the query.
    function automatic t_out_item classify_sample(input t_in_item s);
        t_out_item r;
        logic      fall;
        r    = '0;
        fall = 1'b0;
        if (!m_primed) begin
            // The very first sample only records the level. A button held at start-up
            // leaves the release counter at zero so its release will not count.
            m_primed   = 1'b1;
            m_level    = s.pressed_level;
            m_releases = s.pressed_level ? 8'd0 : 8'd1;
        end else begin
            if (s.pressed_level != m_level) begin
                m_level = s.pressed_level;
                if (s.pressed_level) begin
                    m_press_at  = s.now_tick;
                    r.new_press = 1'b1;
                end else begin
                    if (m_releases != 8'd0) begin
                        m_release_at = s.now_tick;
                        fall         = 1'b1;
                    end
                    m_releases = m_releases + 8'd1;
                end
            end
            // Durations only move when the sample time is not behind the stamp.
            if (m_level) begin
                if (s.now_tick >= m_press_at)
                    m_hold = s.now_tick - m_press_at;
            end else if (s.now_tick >= m_release_at) begin
                m_gap = s.now_tick - m_release_at;
                if (m_gap > {16'd0, m_window})
                    m_burst = 8'd0;
            end
            if (fall)
                m_burst = m_burst + 8'd1;
            r.new_release = fall;
            r.short_click = fall && (m_hold <= {16'd0, m_short_limit});
            r.long_click  = fall && (m_hold >  {16'd0, m_short_limit});
            if (s.query_enable && m_burst >= s.press_target) begin
                m_burst           = 8'd0;
                r.multi_press_hit = 1'b1;
            end
        end
        r.is_pressed        = m_level;
        r.hold_ticks        = m_hold;
        r.gap_ticks         = m_gap;
        r.consecutive_count = m_burst;
        r.release_tally     = m_releases;
        r.last_press_time   = m_press_at;
        r.last_release_time = m_release_at;
        return r;
    endfunction

    // Offers one sample and returns at the edge where it is taken. The valid line stays
    // high on return, so samples can follow back to back; idle cycles are
    // inserted at random before the sample is offered.
    task automatic send_sample(input logic level, input logic [31:0] now,
                               input logic query, input logic [7:0] target);
        t_in_item s;
        s               = '0;
        s.pressed_level = level;
        s.now_tick      = now;
        s.query_enable  = query;
        s.press_target  = target;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        do @(posedge i_clk); while (!o_s_tready);
        expected_clicks.push_back(classify_sample(s));
        samples_sent++;
    endtask

    // Stops the sample stream and waits until every predicted result has arrived.
    task automatic wait_for_idle();
        i_s_tvalid <= 1'b0;
        while (expected_clicks.size() != 0)
            @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // Writes both limit registers while the block is idle. Valid stays high across the
    // two writes and is lowered once at the end.
    task automatic set_limits(input logic [15:0] short_lim, input logic [15:0] window);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SHORT_LIMIT;
        i_cfg_data  <= short_lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        m_short_limit = short_lim;
        i_cfg_index <= REG_MULTI_WINDOW;
        i_cfg_data  <= window;
        do @(posedge i_clk); while (!o_cfg_ready);
        m_window    = window;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
                         results_seen, name, want, seen);
        end
    endtask

    // Compares one accepted result with the oldest prediction, field by field.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_clicks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result with no sample waiting for it: 0x%038h", got);
        end else begin
            want = expected_clicks.pop_front();
            check_field("is_pressed",        32'(want.is_pressed),
                        32'(got.is_pressed));
            check_field("new_press",         32'(want.new_press),
                        32'(got.new_press));
            check_field("new_release",       32'(want.new_release),
                        32'(got.new_release));
            check_field("short_click",       32'(want.short_click),
                        32'(got.short_click));
            check_field("long_click",        32'(want.long_click),
                        32'(got.long_click));
            check_field("multi_press_hit",   32'(want.multi_press_hit),
                        32'(got.multi_press_hit));
            check_field("hold_ticks",        want.hold_ticks,        got.hold_ticks);
            check_field("gap_ticks",         want.gap_ticks,         got.gap_ticks);
            check_field("consecutive_count", 32'(want.consecutive_count),
                        32'(got.consecutive_count));
            check_field("release_tally",     32'(want.release_tally),
                        32'(got.release_tally));
            check_field("last_press_time",   want.last_press_time,   got.last_press_time);
            check_field("last_release_time", want.last_release_time, got.last_release_time);
            short_seen += want.short_click;
            long_seen  += want.long_click;
            hits_seen  += want.multi_press_hit;
        end
        results_seen++;
    endtask

    // Result side: values are sampled as they were just before the edge, then the
    // ready line for the next cycle is chosen at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_result(t_out_item'(o_m_tdata));
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Start-up rules and the corner cases, with the limits at their reset values
    // (400 ticks for a short click, 300 ticks of quiet window).
    task automatic test_startup_and_corners();
        // Button already held on the first sample: it only primes, the query is ignored.
        send_sample(1'b1, 32'hFFFF_FFFF, 1'b1, 8'd0);
        // Still held; the hold is measured from the zero press stamp.
        send_sample(1'b1, 32'd5,         1'b0, 8'd0);
        // Release of the start-up press is not counted.
        send_sample(1'b0, 32'd10,        1'b0, 8'd0);
        // Gap is measured from the zero release stamp; a target of zero always hits.
        send_sample(1'b0, 32'd20,        1'b1, 8'd0);
        send_sample(1'b1, 32'd1000,      1'b1, 8'd255);
        // Sample time behind the press stamp: the hold keeps its old value.
        send_sample(1'b1, 32'd500,       1'b0, 8'd0);
        // First counted release, a short click, and the query on the same sample sees it.
        send_sample(1'b0, 32'd1200,      1'b1, 8'd1);
        send_sample(1'b1, 32'd1300,      1'b0, 8'd0);
        send_sample(1'b1, 32'd1800,      1'b0, 8'd0);
        // Held 500 ticks: a long click; one press in the burst is short of two.
        send_sample(1'b0, 32'd1801,      1'b1, 8'd2);
        // Sample time behind the release stamp: the gap keeps its old value.
        send_sample(1'b0, 32'd100,       1'b0, 8'd0);
        send_sample(1'b1, 32'd1850,      1'b0, 8'd0);
        // Second press of the burst reaches the target of two.
        send_sample(1'b0, 32'd1860,      1'b1, 8'd2);
        send_sample(1'b1, 32'd1900,      1'b0, 8'd0);
        send_sample(1'b0, 32'd1910,      1'b0, 8'd0);
        // 301 ticks of quiet is past the window, so the burst clears.
        send_sample(1'b0, 32'd2211,      1'b1, 8'd1);
        // Press and release at the top of the time range, then at zero.
        send_sample(1'b1, 32'hFFFF_FFFF, 1'b0, 8'd0);
        send_sample(1'b0, 32'hFFFF_FFFF, 1'b1, 8'd255);
        send_sample(1'b1, 32'd0,         1'b1, 8'd0);
        send_sample(1'b0, 32'h8000_0000, 1'b1, 8'd1);
    endtask

    // Random click sequences. Most samples follow a running clock with a button that
    // toggles now and then, so holds and gaps straddle the limits; a few samples are
    // late (time behind the stamps) and a few are pure noise.
    task automatic test_random_clicks(input int unsigned count, input logic [31:0] start,
                                      input int unsigned step_max);
        int unsigned roll;
        logic [31:0] now;
        logic [7:0]  target;
        stim_time = start;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_sample(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)),
                            8'($urandom_range(255)));
            end else begin
                stim_time = stim_time + $urandom_range(step_max);
                if ($urandom_range(99) < 35)
                    stim_level = !stim_level;
                now    = (roll < 13) ? stim_time - $urandom_range(2 * step_max + 1, 1)
                                     : stim_time;
                target = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(4));
                send_sample(stim_level, now, ($urandom_range(99) < 15), target);
            end
        end
    endtask

    // Long burst of quick clicks under the widest window and no queries, so the
    // consecutive count rolls over; the release counter rolls over along the way too.
    task automatic test_burst_wrap();
        for (int unsigned n = 0; n < 260; n++) begin
            stim_time = stim_time + $urandom_range(40, 1);
            send_sample(1'b1, stim_time, 1'b0, 8'd0);
            stim_time = stim_time + $urandom_range(40, 1);
            send_sample(1'b0, stim_time, 1'b0, 8'd0);
        end
        send_sample(1'b0, stim_time + 32'd1, 1'b1, 8'd255);
        send_sample(1'b0, stim_time + 32'd2, 1'b1, 8'd0);
        stim_level = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender rarely idles, receiver stalls more than half the time.
        test_startup_and_corners();
        set_limits(16'd0, 16'hFFFF);
        test_random_clicks(200, $urandom(), 30000);

        // Phase two: the other way round, with the opposite extremes of both limits
        // and a start just below the top of the time range so the clock wraps.
        send_idle_pct = 57;
        recv_idle_pct = 6;
        set_limits(16'hFFFF, 16'd0);
        test_random_clicks(200, 32'hFFFF_F000, 30000);

        // Phase three: full rate on both sides, mid-range limits, then the long burst.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(16'd200, 16'd150);
        test_random_clicks(200, $urandom(), 120);
        set_limits(16'($urandom_range(100)), 16'hFFFF);
        test_burst_wrap();

        wait_for_idle();
        $display("Run covered %0d samples over five limit settings and three stall patterns.",
                 samples_sent);
        $display("Checked %0d results: %0d short clicks, %0d long clicks, %0d burst hits.",
                 results_seen, short_seen, long_seen, hits_seen);
        if (mismatches == 0) begin
            $display("** button_click_classifier: PASSED **");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("** button_click_classifier: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bcc_pkg.sv
rtl/button_click_classifier.sv
tb/button_click_classifier_tb.sv
